### hdl/qvr_pkg.sv
package qvr_pkg;

    // quaternion components on the input bus
    localparam int QUAT_IN_WIDTH = 16;

    // frame selector carried in tuser
    localparam logic FUNC_WORLD = 1'b0;
    localparam logic FUNC_LOCAL = 1'b1;

    // load enables for the two matrix stages
    typedef struct packed {
        logic prod_en;
        logic mat_en;
    } qvr_stage_en_t;

endpackage

### hdl/qvr_matrix.sv
module qvr_matrix #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                                   aclk,
    input  qvr_pkg::qvr_stage_en_t                 stage_en,
    input  logic signed [qvr_pkg::QUAT_IN_WIDTH:0] q_w,
    input  logic signed [qvr_pkg::QUAT_IN_WIDTH:0] q_i,
    input  logic signed [qvr_pkg::QUAT_IN_WIDTH:0] q_j,
    input  logic signed [qvr_pkg::QUAT_IN_WIDTH:0] q_k,
    output logic signed [2*qvr_pkg::QUAT_IN_WIDTH+3-QUAT_FRAC_BITS-1:0] mat [9]
);
    import qvr_pkg::*;

    localparam int QW = QUAT_IN_WIDTH + 1;
    localparam int PW = 2 * QW + 1;
    localparam int MW = PW - QUAT_FRAC_BITS;
    localparam logic signed [PW-1:0] RND = {{(PW-1){1'b0}}, 1'b1} << (QUAT_FRAC_BITS - 1);

    // products: ww ii jj kk ij ik jk wi wj wk
    logic signed [PW-1:0] prod_reg  [10];
    logic signed [PW-1:0] prod_next [10];
    logic signed [MW-1:0] mat_reg   [9];
    logic signed [MW-1:0] mat_next  [9];
    logic signed [PW-1:0] raw       [9];
    logic signed [PW-1:0] rounded   [9];

    always_comb begin
        prod_next[0] = PW'(q_w) * PW'(q_w);
        prod_next[1] = PW'(q_i) * PW'(q_i);
        prod_next[2] = PW'(q_j) * PW'(q_j);
        prod_next[3] = PW'(q_k) * PW'(q_k);
        prod_next[4] = PW'(q_i) * PW'(q_j);
        prod_next[5] = PW'(q_i) * PW'(q_k);
        prod_next[6] = PW'(q_j) * PW'(q_k);
        prod_next[7] = PW'(q_w) * PW'(q_i);
        prod_next[8] = PW'(q_w) * PW'(q_j);
        prod_next[9] = PW'(q_w) * PW'(q_k);
    end

    always_comb begin
        raw[0] = prod_reg[0] + prod_reg[1] - prod_reg[2] - prod_reg[3];
        raw[1] = (prod_reg[4] - prod_reg[9]) <<< 1;
        raw[2] = (prod_reg[5] + prod_reg[8]) <<< 1;
        raw[3] = (prod_reg[4] + prod_reg[9]) <<< 1;
        raw[4] = prod_reg[0] - prod_reg[1] + prod_reg[2] - prod_reg[3];
        raw[5] = (prod_reg[6] - prod_reg[7]) <<< 1;
        raw[6] = (prod_reg[5] - prod_reg[8]) <<< 1;
        raw[7] = (prod_reg[6] + prod_reg[7]) <<< 1;
        raw[8] = prod_reg[0] - prod_reg[1] - prod_reg[2] + prod_reg[3];
        // round half up back to Q.F
        for (int n = 0; n < 9; n++) begin
            rounded[n]  = (raw[n] + RND) >>> QUAT_FRAC_BITS;
            mat_next[n] = rounded[n][MW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.prod_en) begin
            prod_reg <= prod_next;
        end
        if (stage_en.mat_en) begin
            mat_reg <= mat_next;
        end
    end

    assign mat = mat_reg;

endmodule

### hdl/quaternion_vector_rotate.sv
// channel | tdata (low bit up)                          | tuser     | dir
// s_      | vec_x vec_y vec_z quat_w quat_i quat_j quat_k | func      | in
// m_      | out_x out_y out_z                           | saturated | out
//
// Five register stages: input/conjugate, quaternion products, matrix entries,
// matrix-vector products, sum/round/saturate. One transfer per cycle unless m_ stalls back to the input.
// Latency is set by the two multiplier stages and the rounding adds.
// aresetn (sync, active low) clears only the stage valid bits.
// A stalled m_ side holds each full stage; empty stages still fill behind it.
module quaternion_vector_rotate #(
    parameter int VEC_WIDTH      = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // vec_x, vec_y, vec_z, quat_w, quat_i, quat_j, quat_k
    input  logic [((3*VEC_WIDTH+4*qvr_pkg::QUAT_IN_WIDTH+7)/8)*8-1:0] s_tdata,
    // func
    input  logic [0:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // out_x, out_y, out_z
    output logic [((3*VEC_WIDTH+7)/8)*8-1:0] m_tdata,
    // saturated
    output logic [0:0] m_tuser
);
    import qvr_pkg::*;

    localparam int VW   = VEC_WIDTH;
    localparam int QIW  = QUAT_IN_WIDTH;
    localparam int QW   = QIW + 1;
    localparam int PW   = 2 * QW + 1;
    localparam int MW   = PW - QUAT_FRAC_BITS;
    localparam int MV   = MW + VW;
    localparam int AW   = MV + 2;
    localparam int OTW  = ((3 * VW + 7) / 8) * 8;
    localparam int NSTG = 5;
    localparam logic signed [AW-1:0] RND    = {{(AW-1){1'b0}}, 1'b1} << (QUAT_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] SAT_HI = {{(AW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] ld;

    // stage 0: input capture, conjugated when func is local
    logic signed [QW-1:0] q_reg  [4];
    logic signed [QW-1:0] q_next [4];
    logic signed [QW-1:0] q_in   [4];
    logic signed [VW-1:0] v0_reg [3];
    logic signed [VW-1:0] v0_next[3];
    logic signed [VW-1:0] v1_reg [3];
    logic signed [VW-1:0] v2_reg [3];

    // stage 3 and 4
    logic signed [MW-1:0] mat     [9];
    logic signed [MV-1:0] mv_reg  [9];
    logic signed [MV-1:0] mv_next [9];
    logic signed [AW-1:0] acc     [3];
    logic signed [AW-1:0] shifted [3];
    logic signed [VW-1:0] out_reg [3];
    logic signed [VW-1:0] out_next[3];
    logic                 sat_reg;
    logic                 sat_next;

    qvr_stage_en_t stage_en;

    // a stage loads when it is empty or the one after it loads
    always_comb begin
        ld[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            ld[s] = !vld_reg[s] || ld[s+1];
        end
        vld_next[0] = ld[0] ? s_tvalid : vld_reg[0];
        for (int s = 1; s < NSTG; s++) begin
            vld_next[s] = ld[s] ? vld_reg[s-1] : vld_reg[s];
        end
    end

    assign s_tready = ld[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            v0_next[c] = s_tdata[c*VW +: VW];
        end
        for (int c = 0; c < 4; c++) begin
            q_in[c] = QW'($signed(s_tdata[3*VW + c*QIW +: QIW]));
        end
        q_next[0] = q_in[0];
        for (int c = 1; c < 4; c++) begin
            q_next[c] = (s_tuser[0] == FUNC_LOCAL) ? -q_in[c] : q_in[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            q_reg  <= q_next;
            v0_reg <= v0_next;
        end
        if (ld[1]) begin
            v1_reg <= v0_reg;
        end
        if (ld[2]) begin
            v2_reg <= v1_reg;
        end
        if (ld[3]) begin
            mv_reg <= mv_next;
        end
        if (ld[4]) begin
            out_reg <= out_next;
            sat_reg <= sat_next;
        end
    end

    assign stage_en.prod_en = ld[1];
    assign stage_en.mat_en  = ld[2];

    qvr_matrix #(
        .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
    ) u_matrix (
        .aclk     (aclk),
        .stage_en (stage_en),
        .q_w      (q_reg[0]),
        .q_i      (q_reg[1]),
        .q_j      (q_reg[2]),
        .q_k      (q_reg[3]),
        .mat      (mat)
    );

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                mv_next[3*r+c] = MV'(mat[3*r+c]) * MV'(v2_reg[c]);
            end
        end
    end

    always_comb begin
        sat_next = 1'b0;
        for (int r = 0; r < 3; r++) begin
            acc[r] = AW'(mv_reg[3*r]) + AW'(mv_reg[3*r+1]) + AW'(mv_reg[3*r+2]);
            shifted[r] = (acc[r] + RND) >>> QUAT_FRAC_BITS;
            if (shifted[r] > SAT_HI) begin
                out_next[r] = SAT_HI[VW-1:0];
                sat_next    = 1'b1;
            end else if (shifted[r] < SAT_LO) begin
                out_next[r] = SAT_LO[VW-1:0];
                sat_next    = 1'b1;
            end else begin
                out_next[r] = shifted[r][VW-1:0];
            end
        end
    end

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = OTW'({out_reg[2], out_reg[1], out_reg[0]});
    assign m_tuser  = sat_reg;

`ifndef SYNTH
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("pipeline not empty after reset");

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == !((&vld_reg) && !m_tready))
        else $error("s_tready does not match pipeline occupancy");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[2] && !ld[3] |=> vld_reg[2] && $stable(mat[0]) && $stable(mat[8]))
        else $error("matrix stage lost data during stall");

    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            out_reg[0] == SAT_HI[VW-1:0] || out_reg[0] == SAT_LO[VW-1:0] ||
            out_reg[1] == SAT_HI[VW-1:0] || out_reg[1] == SAT_LO[VW-1:0] ||
            out_reg[2] == SAT_HI[VW-1:0] || out_reg[2] == SAT_LO[VW-1:0])
        else $error("saturated flag without a clipped component");
`endif

endmodule
